@@ design/c2p_pkg.sv @@
// shared constants, control struct and constant functions for the
// cartesian to polar converter; no dependencies
`default_nettype none

package c2p_pkg;

    // default configuration
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int ITERATIONS_DEF   = 16;

    // fixed-point layout of the working values
    localparam int GUARD_BITS = 16;
    localparam int ANGLE_FRAC = 30;
    localparam int Z_WIDTH    = 35;
    localparam int GAIN_WIDTH = 30;
    localparam int X_HEADROOM = 2;

    // pi and the reciprocal of the cordic gain at 2^-30
    localparam logic signed [Z_WIDTH-1:0] PI_Q30   = 35'sd3373259426;
    localparam logic [GAIN_WIDTH-1:0]     GAIN_Q30 = 30'd652032874;

    // arctangent of 2^-i at 2^-30 rad, rounded to nearest, first eleven steps
    localparam logic [ANGLE_FRAC-1:0] ATAN_LOW [11] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576
    };

    // per-stage control travelling with the data
    typedef struct packed {
        logic valid;
        logic bypass;
        logic x_neg;
    } c2p_ctl_t;

    // micro-rotation angle for step i
    function automatic logic signed [Z_WIDTH-1:0] atan_q30(input int i);
        logic signed [Z_WIDTH-1:0] res;
        res = '0;
        if (i < 11)
            res = $signed({{(Z_WIDTH-ANGLE_FRAC){1'b0}}, ATAN_LOW[i[3:0]]});
        else if (i <= ANGLE_FRAC)
            res = $signed(Z_WIDTH'(1) << (ANGLE_FRAC - i));
        return res;
    endfunction

    // pi rounded to the phase output grid for a sample width w
    function automatic logic signed [Z_WIDTH-1:0] pi_round(input int w);
        int ps;
        logic signed [Z_WIDTH-1:0] half;
        ps   = 33 - w;
        half = $signed(Z_WIDTH'(1) << (ps - 1));
        return (PI_Q30 + half) >>> ps;
    endfunction

endpackage

`default_nettype wire

@@ design/c2p_prerot.sv @@
// input stage: quadrant pre-rotation into the right half plane and
// zero-y detection; uses c2p_pkg
`default_nettype none

module c2p_prerot #(
    parameter int SAMPLE_WIDTH = c2p_pkg::SAMPLE_WIDTH_DEF,
    parameter int XW           = SAMPLE_WIDTH + c2p_pkg::GUARD_BITS + c2p_pkg::X_HEADROOM
) (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  wire                                        en,
    input  wire                                        in_valid,
    input  wire  logic signed [SAMPLE_WIDTH-1:0]       x_sample,
    input  wire  logic signed [SAMPLE_WIDTH-1:0]       y_sample,
    output c2p_pkg::c2p_ctl_t                          ctl_out,
    output logic signed [XW-1:0]                       x_out,
    output logic signed [XW-1:0]                       y_out,
    output logic signed [c2p_pkg::Z_WIDTH-1:0]         z_out,
    output logic [SAMPLE_WIDTH-1:0]                    absx_out
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int G  = c2p_pkg::GUARD_BITS;
    localparam int ZW = c2p_pkg::Z_WIDTH;

    c2p_pkg::c2p_ctl_t         ctl_reg, ctl_next;
    logic signed [XW-1:0]      x_reg, x_next;
    logic signed [XW-1:0]      y_reg, y_next;
    logic signed [ZW-1:0]      z_reg, z_next;
    logic [W-1:0]              absx_reg, absx_next;
    logic signed [W:0]         x_ext, y_ext, x_rot, y_rot;
    logic                      x_neg;

    // rotate by pi when x is negative
    always_comb
    begin
        x_ext = {x_sample[W-1], x_sample};
        y_ext = {y_sample[W-1], y_sample};
        x_neg = x_sample[W-1];
        x_rot = x_neg ? -x_ext : x_ext;
        y_rot = x_neg ? -y_ext : y_ext;
        if (!x_neg)
            z_next = '0;
        else if (!y_sample[W-1])
            z_next = c2p_pkg::PI_Q30;
        else
            z_next = -c2p_pkg::PI_Q30;
        x_next    = {{(XW-G-W-1){x_rot[W]}}, x_rot, {G{1'b0}}};
        y_next    = {{(XW-G-W-1){y_rot[W]}}, y_rot, {G{1'b0}}};
        absx_next = x_rot[W-1:0];
        ctl_next.valid  = in_valid;
        ctl_next.bypass = (y_sample == '0);
        ctl_next.x_neg  = x_neg;
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            absx_reg <= absx_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign absx_out = absx_reg;

endmodule

`default_nettype wire

@@ design/c2p_cordic_stage.sv @@
// one registered cordic vectoring micro-rotation, shift and angle set
// by the stage index; uses c2p_pkg
`default_nettype none

module c2p_cordic_stage #(
    parameter int SAMPLE_WIDTH = c2p_pkg::SAMPLE_WIDTH_DEF,
    parameter int XW           = SAMPLE_WIDTH + c2p_pkg::GUARD_BITS + c2p_pkg::X_HEADROOM,
    parameter int STAGE_IDX    = 0
) (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  wire                                        en,
    input  wire  c2p_pkg::c2p_ctl_t                    ctl_in,
    input  wire  logic signed [XW-1:0]                 x_in,
    input  wire  logic signed [XW-1:0]                 y_in,
    input  wire  logic signed [c2p_pkg::Z_WIDTH-1:0]   z_in,
    input  wire  logic [SAMPLE_WIDTH-1:0]              absx_in,
    output c2p_pkg::c2p_ctl_t                          ctl_out,
    output logic signed [XW-1:0]                       x_out,
    output logic signed [XW-1:0]                       y_out,
    output logic signed [c2p_pkg::Z_WIDTH-1:0]         z_out,
    output logic [SAMPLE_WIDTH-1:0]                    absx_out
);

    localparam int ZW = c2p_pkg::Z_WIDTH;
    localparam logic signed [ZW-1:0] ATAN = c2p_pkg::atan_q30(STAGE_IDX);

    c2p_pkg::c2p_ctl_t         ctl_reg;
    logic signed [XW-1:0]      x_reg, x_next;
    logic signed [XW-1:0]      y_reg, y_next;
    logic signed [ZW-1:0]      z_reg, z_next;
    logic [SAMPLE_WIDTH-1:0]   absx_reg;
    logic signed [XW-1:0]      dx, dy;

    // rotate towards the x axis, direction from the sign of y
    always_comb
    begin
        dx = y_in >>> STAGE_IDX;
        dy = x_in >>> STAGE_IDX;
        if (!y_in[XW-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            absx_reg <= absx_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign absx_out = absx_reg;

endmodule

`default_nettype wire

@@ design/c2p_gain.sv @@
// gain compensation multiply, split into a high and a low partial
// product of the final x; uses c2p_pkg
`default_nettype none

module c2p_gain #(
    parameter int SAMPLE_WIDTH = c2p_pkg::SAMPLE_WIDTH_DEF,
    parameter int XW           = SAMPLE_WIDTH + c2p_pkg::GUARD_BITS + c2p_pkg::X_HEADROOM
) (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  wire                                        en,
    input  wire  c2p_pkg::c2p_ctl_t                    ctl_in,
    input  wire  logic signed [XW-1:0]                 x_in,
    input  wire  logic signed [c2p_pkg::Z_WIDTH-1:0]   z_in,
    input  wire  logic [SAMPLE_WIDTH-1:0]              absx_in,
    output c2p_pkg::c2p_ctl_t                          ctl_out,
    output logic [SAMPLE_WIDTH+c2p_pkg::GAIN_WIDTH:0]  hi_prod_out,
    output logic [c2p_pkg::GAIN_WIDTH-1:0]             lo_prod_out,
    output logic signed [c2p_pkg::Z_WIDTH-1:0]         z_out,
    output logic [SAMPLE_WIDTH-1:0]                    absx_out
);

    localparam int W   = SAMPLE_WIDTH;
    localparam int G   = c2p_pkg::GUARD_BITS;
    localparam int GW  = c2p_pkg::GAIN_WIDTH;
    localparam int ZW  = c2p_pkg::Z_WIDTH;
    localparam int HIW = XW - 1 - G;

    c2p_pkg::c2p_ctl_t      ctl_reg;
    logic [W+GW:0]          hi_prod_reg, hi_prod_next;
    logic [GW-1:0]          lo_prod_reg, lo_prod_next;
    logic signed [ZW-1:0]   z_reg;
    logic [W-1:0]           absx_reg;
    logic [XW-2:0]          xu;
    logic [HIW-1:0]         x_hi;
    logic [G-1:0]           x_lo;
    logic [G+GW-1:0]        lo_full;

    // clamp at zero, then the two partial products
    always_comb
    begin
        xu           = x_in[XW-1] ? '0 : x_in[XW-2:0];
        x_hi         = xu[XW-2:G];
        x_lo         = xu[G-1:0];
        hi_prod_next = x_hi * c2p_pkg::GAIN_Q30;
        lo_full      = x_lo * c2p_pkg::GAIN_Q30;
        lo_prod_next = lo_full[G+GW-1:G];
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_prod_reg <= hi_prod_next;
            lo_prod_reg <= lo_prod_next;
            z_reg       <= z_in;
            absx_reg    <= absx_in;
        end
    end

    assign ctl_out     = ctl_reg;
    assign hi_prod_out = hi_prod_reg;
    assign lo_prod_out = lo_prod_reg;
    assign z_out       = z_reg;
    assign absx_out    = absx_reg;

endmodule

`default_nettype wire

@@ design/c2p_round.sv @@
// output stage: magnitude and phase rounding, saturation, clamp to
// +-pi and the zero-y shortcut; uses c2p_pkg
`default_nettype none

module c2p_round #(
    parameter int SAMPLE_WIDTH = c2p_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire                                              clk,
    input  wire                                              rst_n,
    input  wire                                              en,
    input  wire  c2p_pkg::c2p_ctl_t                          ctl_in,
    input  wire  logic [SAMPLE_WIDTH+c2p_pkg::GAIN_WIDTH:0]  hi_prod_in,
    input  wire  logic [c2p_pkg::GAIN_WIDTH-1:0]             lo_prod_in,
    input  wire  logic signed [c2p_pkg::Z_WIDTH-1:0]         z_in,
    input  wire  logic [SAMPLE_WIDTH-1:0]                    absx_in,
    output logic                                             valid_out,
    output logic [SAMPLE_WIDTH-1:0]                          magnitude_out,
    output logic signed [SAMPLE_WIDTH-1:0]                   phase_out
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int GW = c2p_pkg::GAIN_WIDTH;
    localparam int ZW = c2p_pkg::Z_WIDTH;
    localparam int AF = c2p_pkg::ANGLE_FRAC;
    localparam int PS = 33 - W;
    localparam logic signed [ZW-1:0] PI_OUT   = c2p_pkg::pi_round(W);
    localparam logic signed [ZW:0]   PI_EXT   = $signed({PI_OUT[ZW-1], PI_OUT});
    localparam logic signed [ZW:0]   PH_HALF  = $signed((ZW+1)'(1) << (PS - 1));
    localparam logic [W+GW+1:0]      MAG_HALF = (W+GW+2)'(1) << (AF - 1);

    logic                    valid_reg;
    logic [W-1:0]            magnitude_reg, magnitude_next;
    logic signed [W-1:0]     phase_reg, phase_next;
    logic [W+GW+1:0]         q_sum;
    logic [W+1:0]            mag_full;
    logic signed [ZW:0]      z_round;
    logic signed [ZW:0]      ph_full;
    logic signed [ZW:0]      ph_clamped;

    // round, saturate and clamp
    always_comb
    begin
        q_sum    = {1'b0, hi_prod_in} + {{(W+2){1'b0}}, lo_prod_in} + MAG_HALF;
        mag_full = q_sum[W+GW+1:AF];
        z_round  = {z_in[ZW-1], z_in} + PH_HALF;
        ph_full  = z_round >>> PS;
        if (ph_full > PI_EXT)
            ph_clamped = PI_EXT;
        else if (ph_full < -PI_EXT)
            ph_clamped = -PI_EXT;
        else
            ph_clamped = ph_full;
        if (ctl_in.bypass)
        begin
            magnitude_next = absx_in;
            phase_next     = ctl_in.x_neg ? PI_OUT[W-1:0] : '0;
        end
        else
        begin
            magnitude_next = (mag_full[W+1:W] != 2'b00) ? '1 : mag_full[W-1:0];
            phase_next     = ph_clamped[W-1:0];
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= ctl_in.valid;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            magnitude_reg <= magnitude_next;
            phase_reg     <= phase_next;
        end
    end

    assign valid_out     = valid_reg;
    assign magnitude_out = magnitude_reg;
    assign phase_out     = phase_reg;

endmodule

`default_nettype wire

@@ design/cartesian_to_polar.sv @@
// cartesian to polar converter: pipelined cordic vectoring, top level
// register stages in order: quadrant pre-rotation, micro-rotations, gain products, rounding
// throughput one pair per cycle while the output is not stalled, set by one register stage per micro-rotation
// stalls hold a full stage only while its successor cannot load, so bubbles close up
// reset clears the stage control flags only; data registers are not reset
// uses c2p_pkg, c2p_prerot, c2p_cordic_stage, c2p_gain, c2p_round
`default_nettype none

module cartesian_to_polar #(
    parameter int SAMPLE_WIDTH = c2p_pkg::SAMPLE_WIDTH_DEF,
    parameter int ITERATIONS   = c2p_pkg::ITERATIONS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  sample_valid,
    output logic                                 sample_stall,
    input  wire  logic signed [SAMPLE_WIDTH-1:0] x_sample,
    input  wire  logic signed [SAMPLE_WIDTH-1:0] y_sample,
    output logic                                 result_valid,
    input  wire                                  result_stall,
    output logic [SAMPLE_WIDTH-1:0]              magnitude,
    output logic signed [SAMPLE_WIDTH-1:0]       phase
);

    localparam int W      = SAMPLE_WIDTH;
    localparam int N      = ITERATIONS;
    localparam int XW     = W + c2p_pkg::GUARD_BITS + c2p_pkg::X_HEADROOM;
    localparam int ZW     = c2p_pkg::Z_WIDTH;
    localparam int GW     = c2p_pkg::GAIN_WIDTH;
    localparam int STAGES = N + 3;
    localparam logic signed [ZW-1:0] PI_OUT = c2p_pkg::pi_round(W);

    c2p_pkg::c2p_ctl_t        ctl    [N+2];
    logic signed [XW-1:0]     xs     [N+1];
    logic signed [XW-1:0]     ys     [N+1];
    logic signed [ZW-1:0]     zs     [N+2];
    logic [W-1:0]             absx   [N+2];
    logic [W+GW:0]            hi_prod;
    logic [GW-1:0]            lo_prod;
    logic [STAGES-1:0]        stage_valid;
    logic [STAGES-1:0]        en;

    // stage valid vector
    always_comb
    begin
        for (int k = 0; k < STAGES - 1; k++)
            stage_valid[k] = ctl[k].valid;
        stage_valid[STAGES-1] = result_valid;
    end

    // a stage loads when it is empty or its successor loads
    always_comb
    begin
        en[STAGES-1] = !result_valid || !result_stall;
        for (int k = STAGES - 2; k >= 0; k--)
            en[k] = !stage_valid[k] || en[k+1];
    end

    assign sample_stall = !en[0];

    // quadrant pre-rotation
    c2p_prerot #(
        .SAMPLE_WIDTH (W),
        .XW           (XW)
    ) u_prerot (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en[0]),
        .in_valid (sample_valid),
        .x_sample (x_sample),
        .y_sample (y_sample),
        .ctl_out  (ctl[0]),
        .x_out    (xs[0]),
        .y_out    (ys[0]),
        .z_out    (zs[0]),
        .absx_out (absx[0])
    );

    // micro-rotation chain
    for (genvar i = 0; i < N; i++)
    begin : g_cordic
        c2p_cordic_stage #(
            .SAMPLE_WIDTH (W),
            .XW           (XW),
            .STAGE_IDX    (i)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en[i+1]),
            .ctl_in   (ctl[i]),
            .x_in     (xs[i]),
            .y_in     (ys[i]),
            .z_in     (zs[i]),
            .absx_in  (absx[i]),
            .ctl_out  (ctl[i+1]),
            .x_out    (xs[i+1]),
            .y_out    (ys[i+1]),
            .z_out    (zs[i+1]),
            .absx_out (absx[i+1])
        );
    end

    // gain compensation products
    c2p_gain #(
        .SAMPLE_WIDTH (W),
        .XW           (XW)
    ) u_gain (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en[N+1]),
        .ctl_in      (ctl[N]),
        .x_in        (xs[N]),
        .z_in        (zs[N]),
        .absx_in     (absx[N]),
        .ctl_out     (ctl[N+1]),
        .hi_prod_out (hi_prod),
        .lo_prod_out (lo_prod),
        .z_out       (zs[N+1]),
        .absx_out    (absx[N+1])
    );

    // rounding and output register
    c2p_round #(
        .SAMPLE_WIDTH (W)
    ) u_round (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en[N+2]),
        .ctl_in        (ctl[N+1]),
        .hi_prod_in    (hi_prod),
        .lo_prod_in    (lo_prod),
        .z_in          (zs[N+1]),
        .absx_in       (absx[N+1]),
        .valid_out     (result_valid),
        .magnitude_out (magnitude),
        .phase_out     (phase)
    );

`ifndef ASSERT_OFF
    // input is only held off when every stage holds an item
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (&stage_valid))
        else $error("input stalled while the pipeline has a free stage");

    // a draining output always frees the input
    a_drain_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall) |-> !sample_stall)
        else $error("input stalled although the output is draining");

    // phase stays within plus or minus pi
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($signed(phase) <= PI_OUT) && ($signed(phase) >= -PI_OUT))
        else $error("phase outside the range of plus or minus pi");

    // a stalled result keeps its slot for the next cycle
    a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid && stage_valid[STAGES-1])
        else $error("stalled result lost from the output stage");
`endif

endmodule

`default_nettype wire
